// ----- rtl/camc_pkg.sv -----
`default_nettype none

package camc_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAIT_DISARM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAIT_EXIT   = 1'b1;

	localparam logic [7:0] WAIT_DISARM_RESET = 8'd6;
	localparam logic [7:0] WAIT_EXIT_RESET   = 8'd11;

	// Remote key button codes; the unused code counts as no press
	localparam logic [1:0] BTN_NONE  = 2'd0;
	localparam logic [1:0] BTN_OPEN  = 2'd1;
	localparam logic [1:0] BTN_CLOSE = 2'd2;

	typedef enum logic [2:0] {
		MODE_DISARMED  = 3'd0,
		MODE_DRIVER_IN = 3'd1,
		MODE_DRIVING   = 3'd2,
		MODE_STOPPED   = 3'd3,
		MODE_ARMED     = 3'd4,
		MODE_ALARM     = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		WAIT_NONE   = 2'd0,
		WAIT_DISARM = 2'd1,
		WAIT_EXIT   = 2'd2
	} wait_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_LOCK   = 2'd1,
		ACT_UNLOCK = 2'd2
	} act_t;

	typedef struct packed {
		logic [7:0] wait_after_disarm;
		logic [7:0] wait_after_exit;
	} cfg_t;

	typedef struct packed {
		logic [1:0] remote_button;
		logic       engine_running;
		logic       brake_pressed;
		logic       door_open;
	} item_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] countdown;
		wait_t      wait_kind;
		logic       door_was_open;
	} state_t;

	typedef struct packed {
		act_t       lock_action;
		logic       siren_on;
		logic       chirp;
		logic [1:0] flash_count;
		mode_t      alarm_mode;
		wait_t      waiting_kind;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/camc_cfg.sv -----
`default_nettype none

module camc_cfg
	import camc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// Hold the wait lengths; write one per enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_after_disarm <= WAIT_DISARM_RESET;
			cfg_q.wait_after_exit   <= WAIT_EXIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_WAIT_DISARM: cfg_q.wait_after_disarm <= cfg_data;
				CFG_WAIT_EXIT:   cfg_q.wait_after_exit   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/camc_step.sv -----
`default_nettype none

module camc_step
	import camc_pkg::*;
(
	input  wire cfg_t     cfg,
	input  wire state_t   state,
	input  wire item_t    item,
	output state_t  state_next,
	output result_t result
);

	logic [7:0] disarm_ld;
	logic [7:0] exit_ld;
	logic       closing;
	logic [1:0] btn;

	// A zero wait register acts as one tick
	assign disarm_ld = (cfg.wait_after_disarm == 8'd0) ? 8'd1 : cfg.wait_after_disarm;
	assign exit_ld   = (cfg.wait_after_exit == 8'd0) ? 8'd1 : cfg.wait_after_exit;
	assign closing   = state.door_was_open && !item.door_open;
	assign btn       = (item.remote_button == BTN_OPEN || item.remote_button == BTN_CLOSE) ?
	                   item.remote_button : BTN_NONE;

	always_comb begin
		mode_t      m;
		wait_t      wk;
		act_t       lock;
		logic [7:0] cd;
		logic       chirp_v;
		logic [1:0] flash;
		logic       done;
		logic       ev;

		m       = state.mode;
		wk      = state.wait_kind;
		cd      = state.countdown;
		lock    = ACT_NONE;
		chirp_v = 1'b0;
		flash   = 2'd0;
		done    = 1'b0;
		ev      = 1'b0;

		// Countdown ticks: a button cancels the wait, otherwise count and maybe arm
		if (wk == WAIT_DISARM || wk == WAIT_EXIT) begin
			if (btn != BTN_NONE) begin
				wk = WAIT_NONE;
				cd = 8'd0;
			end else begin
				done = 1'b1;
				ev   = closing || (m == MODE_ARMED && item.door_open);
				if (wk == WAIT_DISARM) begin
					if (ev) begin
						m  = MODE_DRIVER_IN;
						wk = WAIT_NONE;
						cd = 8'd0;
					end else begin
						cd = cd - 8'd1;
					end
				end else begin
					cd = ev ? (exit_ld - 8'd1) : (cd - 8'd1);
				end
				if (wk != WAIT_NONE && cd == 8'd0) begin
					wk = WAIT_NONE;
					if (m == MODE_STOPPED || m == MODE_DRIVER_IN)
						m = MODE_DISARMED;
					lock = ACT_LOCK;
					if (!item.engine_running) begin
						m       = MODE_ARMED;
						chirp_v = 1'b1;
						flash   = 2'd1;
					end
				end
			end
		end

		// Remote button
		if (!done) begin
			unique case (btn)
				BTN_OPEN: begin
					if (m == MODE_ALARM) begin
						m = MODE_ARMED;
					end else begin
						if (m == MODE_STOPPED || m == MODE_ARMED)
							m = MODE_DISARMED;
						lock = ACT_UNLOCK;
						if (!item.engine_running) begin
							chirp_v = 1'b1;
							flash   = 2'd2;
							if (m == MODE_DISARMED) begin
								done = 1'b1;
								if (closing) begin
									m = MODE_DRIVER_IN;
								end else begin
									wk = WAIT_DISARM;
									cd = disarm_ld;
								end
							end
						end
					end
				end
				BTN_CLOSE: begin
					if (m == MODE_STOPPED || m == MODE_DRIVER_IN)
						m = MODE_DISARMED;
					lock = ACT_LOCK;
					if (!item.engine_running) begin
						m       = MODE_ARMED;
						chirp_v = 1'b1;
						flash   = 2'd1;
					end
				end
				default: ;
			endcase
		end

		// Engine, then door event
		if (!done) begin
			if (item.engine_running) begin
				if (m == MODE_DRIVER_IN && item.brake_pressed) begin
					lock = ACT_LOCK;
					m    = MODE_DRIVING;
				end
				if (m == MODE_STOPPED)
					m = MODE_DRIVER_IN;
			end else if (m == MODE_DRIVING) begin
				lock = ACT_UNLOCK;
				m    = MODE_STOPPED;
			end

			ev = closing || (m == MODE_ARMED && item.door_open);
			if (ev) begin
				if (m == MODE_DRIVING)
					m = MODE_DRIVER_IN;
				if (m == MODE_STOPPED) begin
					wk = WAIT_EXIT;
					cd = exit_ld;
				end
				if (m == MODE_ARMED)
					m = MODE_ALARM;
			end
		end

		state_next.mode          = m;
		state_next.countdown     = cd;
		state_next.wait_kind     = wk;
		state_next.door_was_open = item.door_open;

		result.lock_action  = lock;
		result.siren_on     = (m == MODE_ALARM);
		result.chirp        = chirp_v;
		result.flash_count  = flash;
		result.alarm_mode   = m;
		result.waiting_kind = wk;
	end

endmodule

`default_nettype wire

// ----- rtl/car_alarm_mode_controller_top.sv -----
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_ready  remote_button, engine_running, brake_pressed,
//                                           door_open
// out       output     out_valid/out_ready  lock_action, siren_on, chirp, flash_count,
//                                           alarm_mode, waiting_kind
// cfg       input      cfg_wr_en            cfg_index, cfg_data
//
// One item per cycle sustained while the output is taken. An accepted item sits in the
// input register, the combinational mode update logic runs on it and its result is
// loaded into the output register once that register is free or being read. Reset clears the mode
// state and loads the default wait lengths. While the output waits, one more item can
// be held in the input register; in_ready drops only when both are full.
`default_nettype none

module car_alarm_mode_controller_top
	import camc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           remote_button,
	input  wire logic                 engine_running,
	input  wire logic                 brake_pressed,
	input  wire logic                 door_open,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                lock_action,
	output logic                      siren_on,
	output logic                      chirp,
	output logic [1:0]                flash_count,
	output logic [2:0]                alarm_mode,
	output logic [1:0]                waiting_kind,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_next;
	result_t result;
	result_t result_q;
	logic    out_valid_q;
	logic    advance;

	camc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	camc_step u_step (
		.cfg        (cfg),
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (result)
	);

	// Advance when the input register holds an item and the output register is free or being read
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.remote_button  <= remote_button;
			item_s1.engine_running <= engine_running;
			item_s1.brake_pressed  <= brake_pressed;
			item_s1.door_open      <= door_open;
		end
	end

	// Mode state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= MODE_DISARMED;
			state_q.countdown     <= 8'd0;
			state_q.wait_kind     <= WAIT_NONE;
			state_q.door_was_open <= 1'b0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign lock_action  = result_q.lock_action;
	assign siren_on     = result_q.siren_on;
	assign chirp        = result_q.chirp;
	assign flash_count  = result_q.flash_count;
	assign alarm_mode   = result_q.alarm_mode;
	assign waiting_kind = result_q.waiting_kind;

	// A running wait always has ticks left
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.wait_kind != WAIT_NONE) |-> (state_q.countdown != 8'd0))
		else $error("wait active with zero countdown");

	// State moves only when an item passes to the output
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("mode state changed without an item");

	// Input stalls only when both registers are full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled with room available");

	// A chirp always comes with a flash, and a flash always comes with a chirp
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (chirp == (flash_count != 2'd0)))
		else $error("chirp and flash disagree");

endmodule

`default_nettype wire

// ----- sim/tb_car_alarm_mode_controller_top.sv -----
`timescale 1ns / 100ps

module tb_car_alarm_mode_controller_top;
	import camc_pkg::*;

	localparam logic [1:0] BTN_UNUSED   = 2'd3;
	localparam logic [1:0] FLASH_NONE   = 2'd0;
	localparam logic [1:0] FLASH_ARM    = 2'd1;
	localparam logic [1:0] FLASH_DISARM = 2'd2;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 178;
	localparam int HOLD_CYCLES = 60;
	localparam int DIR_ROWS    = 26;

	typedef enum int {SC_NOISE, SC_ALARM, SC_DISARM_WAIT, SC_DRIVE, SC_CANCEL} scenario_t;

	typedef struct packed {
		item_t   stim;
		logic    typed;
		result_t want;
	} dir_row_t;

	localparam result_t UNTYPED = '0;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 in_valid       = 1'b0;
	logic                 in_ready;
	logic [1:0]           remote_button  = BTN_NONE;
	logic                 engine_running = 1'b0;
	logic                 brake_pressed  = 1'b0;
	logic                 door_open      = 1'b0;
	logic                 out_valid;
	logic                 out_ready      = 1'b0;
	logic [1:0]           lock_action;
	logic                 siren_on;
	logic                 chirp;
	logic [1:0]           flash_count;
	logic [2:0]           alarm_mode;
	logic [1:0]           waiting_kind;
	logic                 cfg_wr_en      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index      = CFG_WAIT_DISARM;
	logic [7:0]           cfg_data       = 8'd0;

	// Predicted alarm state and wait registers
	mode_t      st_mode          = MODE_DISARMED;
	logic [7:0] st_count         = 8'd0;
	wait_t      st_wait          = WAIT_NONE;
	logic       st_door_was_open = 1'b0;
	logic [7:0] wait_disarm_reg  = WAIT_DISARM_RESET;
	logic [7:0] wait_exit_reg    = WAIT_EXIT_RESET;
	act_t       tick_lock;
	logic       tick_chirp;
	logic [1:0] tick_flash;

	result_t expected_ticks[$];
	int      sent_items     = 0;
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;
	bit      hold_request   = 1'b0;
	bit      failed         = 1'b0;

	// Directed ticks; typed rows carry the result read straight off the rules
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{'{BTN_NONE, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{ACT_NONE, 1'b0, 1'b0, FLASH_NONE, MODE_DISARMED, WAIT_NONE}},
		'{'{BTN_CLOSE, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{ACT_LOCK, 1'b0, 1'b1, FLASH_ARM, MODE_ARMED, WAIT_NONE}},
		'{'{BTN_NONE, 1'b0, 1'b0, 1'b1}, 1'b1,
			'{ACT_NONE, 1'b1, 1'b0, FLASH_NONE, MODE_ALARM, WAIT_NONE}},
		'{'{BTN_NONE, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{ACT_NONE, 1'b1, 1'b0, FLASH_NONE, MODE_ALARM, WAIT_NONE}},
		'{'{BTN_CLOSE, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{ACT_LOCK, 1'b0, 1'b1, FLASH_ARM, MODE_ARMED, WAIT_NONE}},
		'{'{BTN_NONE, 1'b0, 1'b0, 1'b1}, 1'b0, UNTYPED},
		'{'{BTN_OPEN, 1'b0, 1'b0, 1'b1}, 1'b0, UNTYPED},
		'{'{BTN_OPEN, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_OPEN, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_OPEN, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{ACT_UNLOCK, 1'b0, 1'b1, FLASH_DISARM, MODE_DISARMED, WAIT_DISARM}},
		'{'{BTN_NONE, 1'b0, 1'b0, 1'b1}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b1, 1'b1, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b1, 1'b0, 1'b1}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b1, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b1, 1'b1, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b1, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b1, 1'b1, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b0, 1'b0, 1'b1}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b0, 1'b0, 1'b1}, 1'b0, UNTYPED},
		'{'{BTN_NONE, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_UNUSED, 1'b0, 1'b0, 1'b0}, 1'b0, UNTYPED},
		'{'{BTN_CLOSE, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{ACT_LOCK, 1'b0, 1'b0, FLASH_NONE, MODE_DISARMED, WAIT_NONE}},
		'{'{BTN_OPEN, 1'b1, 1'b0, 1'b0}, 1'b0, UNTYPED}
	};

	car_alarm_mode_controller_top DUT (.*);

	always #5 clk = ~clk;

	function automatic logic coin(int unsigned pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic [7:0] at_least_one(logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	function automatic item_t tick_of(logic [1:0] btn, logic eng, logic brk, logic door);
		item_t it;
		it.remote_button  = btn;
		it.engine_running = eng;
		it.brake_pressed  = brk;
		it.door_open      = door;
		return it;
	endfunction

	// Ticks to run a wait out, sometimes all the way to automatic arming
	function automatic int wait_len(logic [7:0] wait_reg);
		if (coin(33))
			return int'(at_least_one(wait_reg)) + 1;
		return $urandom_range(6, 1);
	endfunction

	task automatic arm_car(input logic engine);
		if (st_mode == MODE_STOPPED || st_mode == MODE_DRIVER_IN)
			st_mode = MODE_DISARMED;
		tick_lock = ACT_LOCK;
		if (!engine) begin
			st_mode    = MODE_ARMED;
			tick_chirp = 1'b1;
			tick_flash = FLASH_ARM;
		end
	endtask

	// Advance the predicted alarm by one sensor tick and form its result
	task automatic advance_alarm(input item_t it, output result_t r);
		logic [1:0] btn;
		logic       closing;
		logic       door_hit;
		logic       tick_done;
		btn = (it.remote_button == BTN_UNUSED) ? BTN_NONE : it.remote_button;
		closing = st_door_was_open && !it.door_open;
		st_door_was_open = it.door_open;
		tick_lock  = ACT_NONE;
		tick_chirp = 1'b0;
		tick_flash = FLASH_NONE;
		tick_done  = 1'b0;

		// count down an active wait unless a button cancels it
		if (st_wait == WAIT_DISARM || st_wait == WAIT_EXIT) begin
			if (btn != BTN_NONE) begin
				st_wait  = WAIT_NONE;
				st_count = 8'd0;
			end else begin
				door_hit = closing || (st_mode == MODE_ARMED && it.door_open);
				if (st_wait == WAIT_DISARM) begin
					if (door_hit) begin
						st_mode  = MODE_DRIVER_IN;
						st_wait  = WAIT_NONE;
						st_count = 8'd0;
					end else
						st_count = st_count - 8'd1;
				end else if (door_hit)
					st_count = at_least_one(wait_exit_reg) - 8'd1;
				else
					st_count = st_count - 8'd1;
				if (st_wait != WAIT_NONE && st_count == 8'd0) begin
					st_wait = WAIT_NONE;
					arm_car(it.engine_running);
				end
				tick_done = 1'b1;
			end
		end

		// remote key
		if (!tick_done) begin
			if (btn == BTN_OPEN) begin
				if (st_mode == MODE_ALARM)
					st_mode = MODE_ARMED;
				else begin
					if (st_mode == MODE_STOPPED || st_mode == MODE_ARMED)
						st_mode = MODE_DISARMED;
					tick_lock = ACT_UNLOCK;
					if (!it.engine_running) begin
						tick_chirp = 1'b1;
						tick_flash = FLASH_DISARM;
						if (st_mode == MODE_DISARMED) begin
							tick_done = 1'b1;
							if (closing)
								st_mode = MODE_DRIVER_IN;
							else begin
								st_wait  = WAIT_DISARM;
								st_count = at_least_one(wait_disarm_reg);
							end
						end
					end
				end
			end else if (btn == BTN_CLOSE)
				arm_car(it.engine_running);
		end

		// engine, then the door
		if (!tick_done) begin
			if (it.engine_running) begin
				if (st_mode == MODE_DRIVER_IN && it.brake_pressed) begin
					tick_lock = ACT_LOCK;
					st_mode   = MODE_DRIVING;
				end
				if (st_mode == MODE_STOPPED)
					st_mode = MODE_DRIVER_IN;
			end else if (st_mode == MODE_DRIVING) begin
				tick_lock = ACT_UNLOCK;
				st_mode   = MODE_STOPPED;
			end
			if (closing || (st_mode == MODE_ARMED && it.door_open)) begin
				if (st_mode == MODE_DRIVING)
					st_mode = MODE_DRIVER_IN;
				if (st_mode == MODE_STOPPED) begin
					st_wait  = WAIT_EXIT;
					st_count = at_least_one(wait_exit_reg);
				end
				if (st_mode == MODE_ARMED)
					st_mode = MODE_ALARM;
			end
		end

		r.lock_action  = tick_lock;
		r.siren_on     = (st_mode == MODE_ALARM);
		r.chirp        = tick_chirp;
		r.flash_count  = tick_flash;
		r.alarm_mode   = st_mode;
		r.waiting_kind = st_wait;
	endtask

	// Offer one item; called and left at a falling edge with in_valid held high
	task automatic offer_tick(input item_t it, input logic typed, input result_t want);
		result_t predicted;
		while (coin(send_idle_pct)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		remote_button  <= it.remote_button;
		engine_running <= it.engine_running;
		brake_pressed  <= it.brake_pressed;
		door_open      <= it.door_open;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_alarm(it, predicted);
		expected_ticks.push_back(typed ? want : predicted);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic push_tick(input item_t it);
		offer_tick(it, 1'b0, UNTYPED);
	endtask

	// Quiet ticks: door shut, no key press
	task automatic quiet_ticks(input int n);
		repeat (n)
			push_tick(tick_of(coin(6) ? BTN_UNUSED : BTN_NONE, coin(10), coin(50), 1'b0));
	endtask

	// Hold the input until every result is out and the pipeline is empty
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(negedge clk);
		repeat (3)
			@(negedge clk);
	endtask

	task automatic write_waits(input logic [7:0] disarm_ticks, input logic [7:0] exit_ticks);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_WAIT_DISARM;
		cfg_data  <= disarm_ticks;
		@(negedge clk);
		cfg_index <= CFG_WAIT_EXIT;
		cfg_data  <= exit_ticks;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		wait_disarm_reg = disarm_ticks;
		wait_exit_reg   = exit_ticks;
	endtask

	task automatic run_scenario(input scenario_t kind);
		case (kind)
		SC_NOISE: begin
			repeat ($urandom_range(8, 2))
				push_tick(tick_of(2'($urandom_range(3)), coin(50), coin(50), coin(50)));
		end
		SC_ALARM: begin
			push_tick(tick_of(BTN_NONE, 1'b0, coin(50), 1'b0));
			push_tick(tick_of(BTN_CLOSE, 1'b0, coin(50), 1'b0));
			quiet_ticks($urandom_range(2, 0));
			repeat ($urandom_range(2, 1))
				push_tick(tick_of(BTN_NONE, coin(20), coin(50), 1'b1));
			repeat ($urandom_range(3, 1))
				push_tick(tick_of(coin(70) ? BTN_OPEN : BTN_CLOSE, coin(20), coin(50),
					coin(50)));
		end
		SC_DISARM_WAIT: begin
			push_tick(tick_of(BTN_NONE, 1'b0, coin(50), 1'b0));
			push_tick(tick_of(BTN_CLOSE, 1'b0, coin(50), 1'b0));
			push_tick(tick_of(BTN_OPEN, coin(10), coin(50), 1'b0));
			if (coin(60))
				quiet_ticks(wait_len(wait_disarm_reg));
			else begin
				quiet_ticks($urandom_range(3, 0));
				push_tick(tick_of(BTN_NONE, coin(20), coin(50), 1'b1));
				push_tick(tick_of(BTN_NONE, coin(20), coin(50), 1'b0));
			end
		end
		SC_DRIVE: begin
			// driver gets in, drives, stops and walks away
			push_tick(tick_of(BTN_NONE, 1'b0, coin(50), 1'b0));
			push_tick(tick_of(BTN_CLOSE, 1'b0, coin(50), 1'b0));
			push_tick(tick_of(BTN_OPEN, 1'b0, coin(50), 1'b0));
			push_tick(tick_of(BTN_NONE, 1'b0, coin(50), 1'b1));
			push_tick(tick_of(BTN_NONE, 1'b0, coin(50), 1'b0));
			repeat ($urandom_range(3, 1))
				push_tick(tick_of(BTN_NONE, 1'b1, coin(60), 1'b0));
			repeat ($urandom_range(4, 0))
				push_tick(tick_of(BTN_NONE, 1'b1, coin(50), coin(15)));
			push_tick(tick_of(BTN_NONE, 1'b0, coin(50), 1'b0));
			if (coin(25))
				push_tick(tick_of(BTN_NONE, 1'b1, coin(50), 1'b0));
			push_tick(tick_of(BTN_NONE, 1'b0, coin(50), 1'b1));
			push_tick(tick_of(BTN_NONE, 1'b0, coin(50), 1'b0));
			if (coin(40)) begin
				quiet_ticks($urandom_range(3, 1));
				push_tick(tick_of(BTN_NONE, 1'b0, coin(50), 1'b1));
				push_tick(tick_of(BTN_NONE, 1'b0, coin(50), 1'b0));
			end
			quiet_ticks(wait_len(wait_exit_reg));
		end
		default: begin
			// cancel a running wait with a key press
			push_tick(tick_of(BTN_NONE, 1'b0, coin(50), 1'b0));
			push_tick(tick_of(BTN_CLOSE, 1'b0, coin(50), 1'b0));
			push_tick(tick_of(BTN_OPEN, 1'b0, coin(50), 1'b0));
			quiet_ticks($urandom_range(3, 0));
			push_tick(tick_of(coin(50) ? BTN_OPEN : BTN_CLOSE, coin(40), coin(50), 1'b0));
		end
		endcase
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= !coin(recv_stall_pct);
		end
	end

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			failed = 1'b1;
		end
	endfunction

	// Check each result against the oldest prediction
	always @(posedge clk) begin : check_result
		result_t want;
		if (out_valid && out_ready) begin
			if (expected_ticks.size() == 0) begin
				$display("%0t: unexpected result, expected none, got mode %0d", $time,
					alarm_mode);
				failed = 1'b1;
			end else begin
				want = expected_ticks.pop_front();
				compare_field("lock_action", want.lock_action, lock_action);
				compare_field("siren_on", want.siren_on, siren_on);
				compare_field("chirp", want.chirp, chirp);
				compare_field("flash_count", want.flash_count, flash_count);
				compare_field("alarm_mode", want.alarm_mode, alarm_mode);
				compare_field("waiting_kind", want.waiting_kind, waiting_kind);
			end
		end
	end

	initial begin : stimulus
		int         start;
		logic [7:0] disarm_ticks;
		logic [7:0] exit_ticks;
		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed ticks at reset wait lengths
		for (int i = 0; i < DIR_ROWS; i++)
			offer_tick(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

		// random phases, each with its own wait lengths and idling
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph)
			0: begin disarm_ticks = 8'd0;   exit_ticks = 8'd255; end
			1: begin disarm_ticks = 8'd255; exit_ticks = 8'd0;   end
			2: begin disarm_ticks = 8'd1;   exit_ticks = 8'd1;   end
			3: begin disarm_ticks = 8'd2;   exit_ticks = 8'd5;   end
			4: begin
				disarm_ticks = 8'($urandom_range(10, 1));
				exit_ticks   = 8'($urandom_range(10, 1));
			end
			5: begin
				disarm_ticks = 8'($urandom_range(255));
				exit_ticks   = 8'($urandom_range(255));
			end
			6: begin disarm_ticks = 8'd3;   exit_ticks = 8'd2;   end
			default: begin
				disarm_ticks = 8'($urandom_range(4, 1));
				exit_ticks   = 8'($urandom_range(4, 1));
			end
			endcase
			write_waits(disarm_ticks, exit_ticks);
			case (ph % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
			default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			start = sent_items;
			// fill the block against a held-off receiver
			if (ph == 4) begin
				hold_request = 1'b1;
				repeat (24)
					push_tick(tick_of(2'($urandom_range(3)), coin(50), coin(50), coin(50)));
			end
			while (sent_items - start < PHASE_ITEMS)
				run_scenario(scenario_t'($urandom_range(4)));
		end

		drain_results();
		repeat (10)
			@(negedge clk);
		if (!failed && expected_ticks.size() == 0)
			$display("car_alarm_mode_controller_top verification clean");
		else
			$display("car_alarm_mode_controller_top verification failed");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("car_alarm_mode_controller_top verification failed");
		$finish;
	end

endmodule

// ----- car_alarm_mode_controller_top.f -----
rtl/camc_pkg.sv
rtl/camc_cfg.sv
rtl/camc_step.sv
rtl/car_alarm_mode_controller_top.sv
sim/tb_car_alarm_mode_controller_top.sv
